### hw/rtl/tpvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvf_pkg
// Shared types and constants for the two-phase V/f sine PWM controller.
// ----------------------------------------------------------------------------
package tpvf_pkg;

  // Action codes carried on the input tuser
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_OVF   = 2'd2,
    ACT_TABLE = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [1:0] REG_DEAD_TIME  = 2'd1;
  localparam logic [1:0] REG_MIN_FREQ   = 2'd2;
  localparam logic [1:0] REG_MAX_FREQ   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register reset values
  localparam logic [9:0] RST_PWM_PERIOD = 10'd800;
  localparam logic [8:0] RST_DEAD_TIME  = 9'd20;
  localparam logic [7:0] RST_MIN_FREQ   = 8'd5;
  localparam logic [7:0] RST_MAX_FREQ   = 8'd50;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [9:0] CMP_MAX    = 10'd1023;

  // Divider geometry: quotient is capped to DIV_Q_W bits (saturates)
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_Q_W   = 11;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  // What the shared divider is working on
  typedef enum logic [1:0] {
    JOB_SAMPLE = 2'd0,
    JOB_MEAN   = 2'd1,
    JOB_PAIR   = 2'd2
  } job_t;

  // Input tdata, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  table_value;
    logic [8:0]  table_index;
    logic [15:0] timestamp;
    logic        pin_level;
  } in_item_t;

  // Output tdata, lowest field last
  typedef struct packed {
    logic [4:0] pad;
    logic       restart_timer;
    logic [7:0] frequency;
    logic       fan_on;
    logic       pwm_running;
    logic [9:0] cmp_quad_b;
    logic [9:0] cmp_quad_a;
    logic [9:0] cmp_main_b;
    logic [9:0] cmp_main_a;
  } out_item_t;

endpackage

### hw/rtl/tpvf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpvf_div
// Restoring divider, one quotient bit per cycle, quotient saturates to all
// ones when it would not fit in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module tpvf_div import tpvf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_Q_W-1:0]   low;
  logic [DIV_Q_W-1:0]   quo;
  logic [DIV_DEN_W-1:0] num_hi;
  logic                 ovf;
  logic [DIV_DEN_W:0]   trial;
  logic                 take;

  assign num_hi = DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
  assign ovf    = num_hi >= req.den;
  assign trial  = {rem, low[DIV_Q_W-1]};
  assign take   = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= !ovf;
        done <= ovf;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= ovf ? '0 : num_hi;
      low <= req.num[DIV_Q_W-1:0];
      quo <= ovf ? '1 : '0;
      dvs <= req.den;
      cnt <= DIV_CNT_W'(DIV_Q_W);
    end else if (busy) begin
      rem <= take ? DIV_DEN_W'(trial - {1'b0, dvs}) : DIV_DEN_W'(trial);
      quo <= {quo[DIV_Q_W-2:0], take};
      low <= {low[DIV_Q_W-2:0], 1'b0};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

### hw/rtl/two_phase_vf_sine_pwm_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_vf_sine_pwm_controller_top
// Throughput: one transaction at a time. The shared divider serves two
//   quotients per tick and one or two per ring update.
// The result register frees the input side as soon as it is loaded.
// Reset (rst, synchronous, active high) restores register defaults, empties
//   the average ring via its fill flag and sets all compares to 400.
// ----------------------------------------------------------------------------
// Volts-per-hertz drive for two phases 90 degrees apart. Control edges are
// timestamped to measure duty, samples are averaged over a ring, and the mean
// sets the phase step and the sine amplitude. Each tick produces complementary
// compare pairs for the main and quadrature phases from a half-sine table.
// ----------------------------------------------------------------------------
module two_phase_vf_sine_pwm_controller_top import tpvf_pkg::*; #(
  parameter int TABLE_DEPTH = 512,
  parameter int AVG_DEPTH   = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pin_level[0], timestamp[16:1], table_index[25:17], table_value[33:26]
  input  logic [39:0]           s_axis_tdata,
  // action[1:0]
  input  logic [1:0]            s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // cmp_main_a[9:0], cmp_main_b[19:10], cmp_quad_a[29:20], cmp_quad_b[39:30],
  // pwm_running[40], fan_on[41], frequency[49:42], restart_timer[50]
  output logic [55:0]           m_axis_tdata
);

  // Phase space is two table lengths; table index wraps at TABLE_DEPTH.
  localparam int SPAN  = 2 * TABLE_DEPTH;
  localparam int PH_W  = $clog2(SPAN);
  localparam int QS_W  = PH_W + 1;
  localparam int WS_W  = $clog2(SPAN + 256);
  localparam int TA_W  = $clog2(TABLE_DEPTH);
  localparam int RP_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int RS_W  = $clog2(AVG_DEPTH * 255 + 1);
  localparam int HM_W  = 17;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DECODE   = 14'b00000000000010,
    S_SMP_MUL  = 14'b00000000000100,
    S_DIV_GO   = 14'b00000000001000,
    S_DIV_WAIT = 14'b00000000010000,
    S_RING_RD  = 14'b00000000100000,
    S_RING_UPD = 14'b00000001000000,
    S_ADDR     = 14'b00000010000000,
    S_TAB_RD   = 14'b00000100000000,
    S_MUL      = 14'b00001000000000,
    S_PAIR_A   = 14'b00010000000000,
    S_PAIR_B   = 14'b00100000000000,
    S_WRAP     = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [9:0] pwm_period;
  logic [8:0] dead_time;
  logic [7:0] min_freq;
  logic [7:0] max_freq;

  // Latched input transaction
  in_item_t   in_w;
  action_t    act_r;
  logic       pin_r;
  logic [15:0] ts_r;
  logic [8:0] tidx_r;
  logic [7:0] tval_r;

  // Controller state
  logic [RP_W-1:0] ring_pos;
  logic            ring_full;
  logic [RS_W-1:0] ring_sum;
  logic [PH_W-1:0] phase_acc;
  logic [7:0]      step_freq;
  logic [7:0]      amp_freq;
  logic [15:0]     fall_time;
  logic [15:0]     rise_time;
  logic            measuring;
  logic            running;
  logic            restart;
  logic [9:0]      cmp [4];

  // Working registers
  job_t                 job;
  logic [15:0]          hi_r;
  logic [15:0]          per_r;
  logic [7:0]           sample;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [PH_W-1:0]      cur_ph;
  logic                 pair_sel;
  logic                 neg;
  logic [TA_W-1:0]      tab_addr;
  logic [HM_W-1:0]      hmul;
  logic [9:0]           a_r;
  logic [WS_W-1:0]      wsum;

  // Memories
  logic [7:0]      sine_mem [TABLE_DEPTH];
  logic [7:0]      tab_q;
  logic            tab_we;
  logic [7:0]      ring_mem [AVG_DEPTH];
  logic [7:0]      ring_q;

  // Divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  out_item_t out_q;

  // Combinational helpers
  logic [8:0]      h;
  logic [7:0]      max_nz;
  logic [7:0]      ring_old;
  logic [RS_W-1:0] ring_sum_next;
  logic [QS_W-1:0] qsum;
  logic [PH_W-1:0] quad_ph;
  logic [11:0]     a_sum;
  logic [9:0]      a_pos;
  logic [9:0]      a_neg;
  logic [9:0]      b_val;
  logic [9:0]      dead10;
  logic [9:0]      a_fin;
  logic [9:0]      b_fin;
  logic [7:0]      mean;
  logic [7:0]      mean_clip;

  assign in_w   = in_item_t'(s_axis_tdata);
  assign h      = pwm_period[9:1];
  assign max_nz = (max_freq == 8'd0) ? 8'd1 : max_freq;
  assign dead10 = 10'(dead_time);

  // Ring entries past the fill point read as zero until the first wrap
  assign ring_old      = ring_full ? ring_q : 8'd0;
  assign ring_sum_next = ring_sum - RS_W'(ring_old) + RS_W'(sample);

  // Quadrature phase is a quarter turn ahead
  assign qsum    = QS_W'(phase_acc) + QS_W'(TABLE_DEPTH / 2);
  assign quad_ph = (qsum >= QS_W'(SPAN)) ? PH_W'(qsum - QS_W'(SPAN)) : PH_W'(qsum);

  // Positive half adds floor(h*x), negative half subtracts ceil(h*x);
  // the capped quotient saturates the same way as the full one.
  assign a_sum = 12'(h) + 12'(div_rsp.quo);
  assign a_pos = (a_sum > 12'(CMP_MAX)) ? CMP_MAX : a_sum[9:0];
  assign a_neg = (div_rsp.quo > DIV_Q_W'(h)) ? 10'd0 : 10'(DIV_Q_W'(h) - div_rsp.quo);

  assign b_val = (a_r > pwm_period) ? 10'd0 : pwm_period - a_r;
  assign a_fin = (a_r < dead10) ? dead10 : a_r;
  assign b_fin = (b_val < dead10) ? dead10 : b_val;

  assign mean      = div_rsp.quo[7:0];
  assign mean_clip = (mean > max_freq) ? max_freq : mean;

  assign tab_we = (state == S_DECODE) && (act_r == ACT_TABLE) &&
                  (32'(tidx_r) < TABLE_DEPTH);

  assign s_axis_tready = (state == S_IDLE);

  // Divider request; ceiling division for the negative half-wave
  always_comb begin
    div_req.start = (state == S_DIV_GO);
    div_req.den   = den_r;
    if (job == JOB_PAIR && neg) begin
      div_req.num = num_r + DIV_NUM_W'(den_r) - DIV_NUM_W'(1);
    end else begin
      div_req.num = num_r;
    end
  end

  tpvf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= RST_PWM_PERIOD;
      dead_time  <= RST_DEAD_TIME;
      min_freq   <= RST_MIN_FREQ;
      max_freq   <= RST_MAX_FREQ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PWM_PERIOD: pwm_period <= cfg_data[9:0];
        REG_DEAD_TIME:  dead_time  <= cfg_data[8:0];
        REG_MIN_FREQ:   min_freq   <= cfg_data[7:0];
        REG_MAX_FREQ:   max_freq   <= cfg_data[7:0];
      endcase
    end
  end

  // Sine table: one write port, registered read
  always_ff @(posedge clk) begin
    if (tab_we) begin
      sine_mem[TA_W'(tidx_r)] <= tval_r;
    end
    tab_q <= sine_mem[tab_addr];
  end

  // Average ring: written in order, so a fill flag stands in for clearing
  always_ff @(posedge clk) begin
    if (state == S_RING_UPD) begin
      ring_mem[ring_pos] <= sample;
    end
    ring_q <= ring_mem[ring_pos];
  end

  // Sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_pos      <= '0;
      ring_full     <= 1'b0;
      ring_sum      <= '0;
      phase_acc     <= '0;
      step_freq     <= RST_MIN_FREQ;
      amp_freq      <= 8'd0;
      fall_time     <= 16'd0;
      rise_time     <= 16'd0;
      measuring     <= 1'b0;
      running       <= 1'b0;
      restart       <= 1'b0;
      job           <= JOB_SAMPLE;
      pair_sel      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cmp[i] <= RST_PWM_PERIOD >> 1;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            restart <= 1'b0;
            state   <= S_DECODE;
          end
        end

        S_DECODE: begin
          unique case (act_r)
            ACT_TICK: begin
              cur_ph   <= phase_acc;
              pair_sel <= 1'b0;
              state    <= S_ADDR;
            end
            ACT_EDGE: begin
              if (pin_r) begin
                rise_time <= ts_r;
                state     <= S_DONE;
              end else if (measuring) begin
                measuring <= 1'b0;
                restart   <= 1'b1;
                hi_r      <= rise_time - fall_time;
                per_r     <= ts_r - fall_time;
                state     <= S_SMP_MUL;
              end else begin
                measuring <= 1'b1;
                fall_time <= ts_r;
                state     <= S_DONE;
              end
            end
            ACT_OVF: begin
              sample <= pin_r ? 8'd0 : max_freq;
              state  <= S_RING_RD;
            end
            ACT_TABLE: begin
              state <= S_DONE;
            end
          endcase
        end

        S_SMP_MUL: begin
          num_r <= DIV_NUM_W'(max_freq) * DIV_NUM_W'(hi_r);
          den_r <= per_r;
          job   <= JOB_SAMPLE;
          if (per_r == 16'd0) begin
            // zero period reads as full duty
            sample <= max_freq;
            state  <= S_RING_RD;
          end else begin
            state <= S_DIV_GO;
          end
        end

        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (job)
              JOB_SAMPLE: begin
                sample <= (div_rsp.quo > DIV_Q_W'(FULL_SCALE)) ? FULL_SCALE
                                                               : div_rsp.quo[7:0];
                state  <= S_RING_RD;
              end
              JOB_MEAN: begin
                if (mean < min_freq) begin
                  running   <= 1'b0;
                  step_freq <= min_freq;
                end else begin
                  running   <= 1'b1;
                  step_freq <= mean_clip;
                  amp_freq  <= mean_clip;
                end
                state <= S_DONE;
              end
              JOB_PAIR: begin
                state <= S_PAIR_A;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_RING_RD: begin
          state <= S_RING_UPD;
        end

        S_RING_UPD: begin
          ring_sum <= ring_sum_next;
          if (ring_pos == RP_W'(AVG_DEPTH - 1)) begin
            ring_pos  <= '0;
            ring_full <= 1'b1;
          end else begin
            ring_pos <= ring_pos + RP_W'(1);
          end
          num_r <= DIV_NUM_W'(ring_sum_next);
          den_r <= DIV_DEN_W'(AVG_DEPTH);
          job   <= JOB_MEAN;
          state <= S_DIV_GO;
        end

        S_ADDR: begin
          if (cur_ph >= PH_W'(TABLE_DEPTH)) begin
            neg      <= 1'b1;
            tab_addr <= TA_W'(cur_ph - PH_W'(TABLE_DEPTH));
          end else begin
            neg      <= 1'b0;
            tab_addr <= TA_W'(cur_ph);
          end
          hmul  <= HM_W'(h) * HM_W'(amp_freq);
          state <= S_TAB_RD;
        end

        S_TAB_RD: begin
          state <= S_MUL;
        end

        S_MUL: begin
          num_r <= DIV_NUM_W'(hmul) * DIV_NUM_W'(tab_q);
          den_r <= DIV_DEN_W'(max_nz) * DIV_DEN_W'(FULL_SCALE);
          job   <= JOB_PAIR;
          state <= S_DIV_GO;
        end

        S_PAIR_A: begin
          a_r   <= neg ? a_neg : a_pos;
          state <= S_PAIR_B;
        end

        S_PAIR_B: begin
          if (pair_sel) begin
            cmp[2] <= a_fin;
            cmp[3] <= b_fin;
            wsum   <= WS_W'(phase_acc) + WS_W'(step_freq);
            state  <= S_WRAP;
          end else begin
            cmp[0]   <= a_fin;
            cmp[1]   <= b_fin;
            pair_sel <= 1'b1;
            cur_ph   <= quad_ph;
            state    <= S_ADDR;
          end
        end

        S_WRAP: begin
          // small tables may need more than one subtraction
          if (wsum >= WS_W'(SPAN)) begin
            wsum <= wsum - WS_W'(SPAN);
          end else begin
            phase_acc <= PH_W'(wsum);
            state     <= S_DONE;
          end
        end

        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid       <= 1'b1;
            out_q.pad           <= '0;
            out_q.restart_timer <= restart;
            out_q.frequency     <= step_freq;
            out_q.fan_on        <= running;
            out_q.pwm_running   <= running;
            out_q.cmp_quad_b    <= cmp[3];
            out_q.cmp_quad_a    <= cmp[2];
            out_q.cmp_main_b    <= cmp[1];
            out_q.cmp_main_a    <= cmp[0];
            state               <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_r  <= action_t'(s_axis_tuser);
      pin_r  <= in_w.pin_level;
      ts_r   <= in_w.timestamp;
      tidx_r <= in_w.table_index;
      tval_r <= in_w.table_value;
    end
  end

  assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside of wait state");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> state == S_DECODE)
    else $error("accepted transaction not decoded");

  a_ring_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_pos <= RP_W'(AVG_DEPTH - 1))
    else $error("ring position out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    QS_W'(phase_acc) < QS_W'(SPAN))
    else $error("phase accumulator out of range");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for two_phase_vf_sine_pwm_controller_top. A scoreboard
// class predicts the result word for every input transaction, including
// compare pairs, the ring average, run/stop state and frequency. It checks
// each output transaction against the oldest prediction. The stimulus loads
// the half-sine table, then runs a short directed pass and seven register
// settings with randomized traffic, varied stream idling, a long output
// hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import tpvf_pkg::*;

  localparam int TABLE_DEPTH    = 512;
  localparam int AVG_DEPTH      = 255;
  localparam int PHASE_SPAN     = 2 * TABLE_DEPTH;
  localparam int SETTLE_CYCLES  = 48;    // longer than one tick plus margin
  localparam int RX_HOLD_CYCLES = 400;   // long output stall, block backs up
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int MAX_REPORTS    = 40;    // keep the log short

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the drive state and registers, turns
  // each accepted input into the expected output word and checks outputs
  // in order.
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    int unsigned period, dead_time, min_freq, max_freq;
    bit [7:0]    sine_tab [TABLE_DEPTH];
    bit [7:0]    ring [AVG_DEPTH];
    int          ring_pos, ring_sum;
    int          phase;
    bit [7:0]    step_freq, amp_freq;
    bit [15:0]   fall_ts, rise_ts;
    bit          meas_open, run_on;
    bit [9:0]    cmp [4];
    out_item_t   queued_outputs [$];
    int          errors, results_seen;

    function new();
      period    = RST_PWM_PERIOD;
      dead_time = RST_DEAD_TIME;
      min_freq  = RST_MIN_FREQ;
      max_freq  = RST_MAX_FREQ;
      foreach (sine_tab[i]) sine_tab[i] = '0;
      foreach (ring[i]) ring[i] = '0;
      ring_pos  = 0;
      ring_sum  = 0;
      phase     = 0;
      step_freq = RST_MIN_FREQ;
      amp_freq  = '0;
      fall_ts   = '0;
      rise_ts   = '0;
      meas_open = 1'b0;
      run_on    = 1'b0;
      foreach (cmp[i]) cmp[i] = RST_PWM_PERIOD >> 1;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PWM_PERIOD: period    = data[9:0];
        REG_DEAD_TIME:  dead_time = data[8:0];
        REG_MIN_FREQ:   min_freq  = data[7:0];
        REG_MAX_FREQ:   max_freq  = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return queued_outputs.size();
    endfunction

    function longint clamp10(longint v);
      if (v < 0) return 0;
      if (v > CMP_MAX) return CMP_MAX;
      return v;
    endfunction

    // complementary pair for one phase position
    function void compare_pair(int ph, output bit [9:0] pa, output bit [9:0] pb);
      longint h, m, num, den, av, a, b;
      h = longint'(period >> 1);
      m = max_freq;
      if (m == 0) m = 1;
      num = h * longint'(amp_freq) * longint'(sine_tab[ph % TABLE_DEPTH]);
      den = longint'(FULL_SCALE) * m;
      // upper half of the phase space is the negative lobe, rounded away
      if (ph < TABLE_DEPTH) av = h + num / den;
      else av = h - (num + den - 1) / den;
      a = clamp10(av);
      b = clamp10(longint'(period) - a);
      if (a < longint'(dead_time)) a = dead_time;
      if (b < longint'(dead_time)) b = dead_time;
      pa = a[9:0];
      pb = b[9:0];
    endfunction

    function void add_sample(int s);
      int mean;
      ring_sum = ring_sum - int'(ring[ring_pos]) + s;
      ring[ring_pos] = s[7:0];
      ring_pos++;
      if (ring_pos >= AVG_DEPTH) ring_pos = 0;
      mean = ring_sum / AVG_DEPTH;
      if (mean < int'(min_freq)) begin
        run_on    = 1'b0;
        step_freq = 8'(min_freq);
      end else begin
        run_on = 1'b1;
        if (mean > int'(max_freq)) mean = max_freq;
        step_freq = 8'(mean);
        amp_freq  = 8'(mean);
      end
    endfunction

    // one accepted input transaction -> one expected output word
    function void note_item(action_t act, in_item_t d);
      out_item_t want;
      bit        restart;
      int        quad, s;
      bit [15:0] hi, per;
      restart = 1'b0;
      case (act)
        ACT_TICK: begin
          quad = (phase + TABLE_DEPTH / 2) % PHASE_SPAN;
          compare_pair(phase, cmp[0], cmp[1]);
          compare_pair(quad, cmp[2], cmp[3]);
          phase = (phase + int'(step_freq)) % PHASE_SPAN;
        end
        ACT_EDGE: begin
          if (d.pin_level) begin
            rise_ts = d.timestamp;
          end else if (meas_open) begin
            hi  = rise_ts - fall_ts;
            per = d.timestamp - fall_ts;
            if (per == 0) begin
              s = max_freq;
            end else begin
              s = (int'(max_freq) * int'(hi)) / int'(per);
              if (s > 255) s = 255;
            end
            add_sample(s);
            meas_open = 1'b0;
            restart   = 1'b1;
          end else begin
            meas_open = 1'b1;
            fall_ts   = d.timestamp;
          end
        end
        ACT_OVF: add_sample(d.pin_level ? 0 : int'(max_freq));
        default: sine_tab[d.table_index] = d.table_value;
      endcase
      want               = '0;
      want.cmp_main_a    = cmp[0];
      want.cmp_main_b    = cmp[1];
      want.cmp_quad_a    = cmp[2];
      want.cmp_quad_b    = cmp[3];
      want.pwm_running   = run_on;
      want.fan_on        = run_on;
      want.frequency     = step_freq;
      want.restart_timer = restart;
      queued_outputs.push_back(want);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                  results_seen, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (queued_outputs.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending",
                                  results_seen));
      end else begin
        want = queued_outputs.pop_front();
        check_field("cmp_main_a", got.cmp_main_a, want.cmp_main_a);
        check_field("cmp_main_b", got.cmp_main_b, want.cmp_main_b);
        check_field("cmp_quad_a", got.cmp_quad_a, want.cmp_quad_a);
        check_field("cmp_quad_b", got.cmp_quad_b, want.cmp_quad_b);
        check_field("pwm_running", got.pwm_running, want.pwm_running);
        check_field("fan_on", got.fan_on, want.fan_on);
        check_field("frequency", got.frequency, want.frequency);
        check_field("restart_timer", got.restart_timer, want.restart_timer);
      end
      results_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals, all inputs at known values from time zero
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PWM_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata = '0;   // pin_level, timestamp, table_index, table_value
  logic [1:0]            s_axis_tuser = ACT_TICK;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [55:0]           m_axis_tdata;  // cmp_main_a, cmp_main_b, cmp_quad_a, cmp_quad_b,
                                        // pwm_running, fan_on, frequency, restart_timer

  drive_scoreboard sb;

  // stream idling, percent of cycles
  int in_idle_pct  = 21;
  int out_idle_pct = 46;

  // output hold-off: main bumps the request count, receiver serves it
  int rx_hold_requests = 0;
  int rx_hold_served   = 0;
  int rx_hold_left     = 0;

  int stall_cycles  = 0;
  int items_offered = 0;

  // sender-side view of the measurement gate, used only to shape stimulus
  bit        gate_open = 1'b0;
  bit [15:0] last_fall = '0;

  always #1 clk = ~clk;

  two_phase_vf_sine_pwm_controller_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AVG_DEPTH  (AVG_DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, or a long hold when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_served != rx_hold_requests) begin
      rx_hold_served <= rx_hold_served + 1;
      rx_hold_left   <= RX_HOLD_CYCLES;
      m_axis_tready  <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check outputs before noting inputs of the same edge, so a new
  // prediction can never be matched against an older result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(out_item_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(action_t'(s_axis_tuser), in_item_t'(s_axis_tdata));
    end
  end

  // Watchdog: any transaction on either side resets the count
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each returns at the edge its transaction was accepted.
  // tvalid stays high into the next item unless a gap is taken, so it never
  // gets two assignments in one time step.
  // --------------------------------------------------------------------------
  task automatic send_item(input action_t act, input in_item_t d);
    if ($urandom_range(99) < in_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    items_offered++;
  endtask

  function automatic in_item_t random_fields();
    in_item_t d;
    d             = '0;
    d.pin_level   = 1'($urandom);
    d.timestamp   = 16'($urandom);
    d.table_index = 9'($urandom);
    d.table_value = 8'($urandom);
    return d;
  endfunction

  task automatic send_tick();
    send_item(ACT_TICK, random_fields());
  endtask

  task automatic send_edge(input bit pin, input bit [15:0] ts);
    in_item_t d;
    d           = random_fields();
    d.pin_level = pin;
    d.timestamp = ts;
    // a falling edge either opens or closes the measurement window
    if (!pin) begin
      gate_open = !gate_open;
      if (gate_open) last_fall = ts;
    end
    send_item(ACT_EDGE, d);
  endtask

  task automatic send_overflow(input bit pin);
    in_item_t d;
    d           = random_fields();
    d.pin_level = pin;
    send_item(ACT_OVF, d);
  endtask

  task automatic send_table_entry(input bit [8:0] idx, input bit [7:0] val);
    in_item_t d;
    d             = random_fields();
    d.table_index = idx;
    d.table_value = val;
    send_item(ACT_TABLE, d);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // pause the sender until every prediction is matched, then let it settle
  task automatic wait_drained();
    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes of all four registers; only called while idle
  task automatic apply_settings(input logic [9:0] per, dead, fmin, fmax);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idx [4];
    vals = '{per, dead, fmin, fmax};
    idx  = '{REG_PWM_PERIOD, REG_DEAD_TIME, REG_MIN_FREQ, REG_MAX_FREQ};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: ticks, complete duty measurements and
  // overflows, plus table rewrites, stray edges and broken measurements.
  task automatic send_random_group();
    int        pick;
    bit [15:0] fall, hi, per;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_tick();
    end else if (pick < 70) begin
      if (gate_open) begin
        fall = last_fall;
      end else begin
        fall = 16'($urandom);
        send_edge(1'b0, fall);
      end
      per = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
      // occasionally a high time longer than the period (sample saturates)
      hi = ($urandom_range(6) == 0) ? 16'($urandom) : 16'($urandom_range(per));
      // occasionally the rising edge goes missing
      if ($urandom_range(9) != 0) send_edge(1'b1, fall + hi);
      send_edge(1'b0, fall + per);
    end else if (pick < 90) begin
      send_overflow(1'($urandom));
    end else if (pick < 95) begin
      send_table_entry(9'($urandom), 8'($urandom));
    end else begin
      send_edge(1'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(input logic [9:0] per, dead, fmin, fmax,
                           input int n_items, input bit hold_rx, input bit pause_mid);
    int start;
    wait_drained();
    apply_settings(per, dead, fmin, fmax);
    if (hold_rx) rx_hold_requests++;
    start = items_offered;
    while (items_offered - start < n_items) begin
      if (pause_mid && (items_offered - start == n_items / 2)) wait_drained();
      send_random_group();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table entry is written before the first tick reads one
    for (int i = 0; i < TABLE_DEPTH; i++) send_table_entry(9'(i), 8'($urandom));

    // directed: ticks at zero amplitude, both overflow samples, a lone
    // rising edge, a zero-length period, a timestamp wrap, a saturated
    // sample and table extremes
    send_tick();
    send_tick();
    send_overflow(1'b1);
    send_overflow(1'b0);
    send_edge(1'b1, 16'hFFFF);
    send_edge(1'b0, 16'h0000);
    send_edge(1'b0, 16'h0000);
    send_edge(1'b0, 16'hFFF0);
    send_edge(1'b1, 16'h0005);
    send_edge(1'b0, 16'h0010);
    send_edge(1'b0, 16'h1000);
    send_edge(1'b1, 16'h8000);
    send_edge(1'b0, 16'h1001);
    send_table_entry(9'd511, 8'd255);
    send_table_entry(9'd0, 8'd0);
    send_table_entry(9'd256, 8'd255);
    send_table_entry(9'd255, 8'd128);
    send_tick();
    send_tick();
    repeat (3) send_overflow(1'b0);
    send_tick();

    // receiver idles more than the sender; long output hold in the first
    // phase; widest period, no dead time, always running, top ceiling
    run_phase(10'd1023, 10'd0, 10'd0, 10'd255, 136, 1'b1, 1'b0);
    // ceiling dropped to one: leftover amplitude overdrives the compares
    run_phase(10'd1023, 10'd511, 10'd3, 10'd1, 136, 1'b0, 1'b0);

    in_idle_pct  = 46;
    out_idle_pct = 21;
    // narrowest period and a floor that can never be met; drain pause midway
    run_phase(10'd2, 10'd0, 10'd255, 10'd255, 136, 1'b0, 1'b1);
    // zero ceiling: amplitude divisor falls back to one
    run_phase(10'd801, 10'd17, 10'd10, 10'd0, 136, 1'b0, 1'b0);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    // full-width writes, upper bits dropped by the narrower registers
    run_phase(10'($urandom_range(1023, 2)), 10'($urandom), 10'($urandom), 10'($urandom),
              136, 1'b0, 1'b0);
    run_phase(10'($urandom_range(1023, 2)), 10'($urandom), 10'($urandom), 10'($urandom),
              136, 1'b0, 1'b0);
    run_phase(RST_PWM_PERIOD, 10'(RST_DEAD_TIME), 10'(RST_MIN_FREQ), 10'(RST_MAX_FREQ),
              136, 1'b0, 1'b0);

    wait_drained();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tpvf_pkg.sv
hw/rtl/tpvf_div.sv
hw/rtl/two_phase_vf_sine_pwm_controller_top.sv
tb/testbench.sv
